[src/tso_pkg.sv]
// Package with shared types and constants for the accumulator thread core.
package tso_pkg;
    localparam int THREADS = 4;
    localparam int WORD_BITS = 16;
    localparam int MEM_WORDS = 65536;
    localparam int ADDR_BITS = $clog2(MEM_WORDS);
    localparam int TID_BITS = 2;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_EXIT = 2'd2;

    localparam logic [2:0] CFG_BOUND = 3'd0;
    localparam logic [2:0] CFG_LEN0 = 3'd1;
    localparam logic [2:0] CFG_LEN3 = 3'd4;

    typedef enum logic [4:0] {
        OP_LOAD = 5'd0, OP_STORE = 5'd1, OP_FENCE = 5'd2, OP_ADD = 5'd3,
        OP_ADDI = 5'd4, OP_SUB = 5'd5, OP_SUBI = 5'd6, OP_MUL = 5'd7,
        OP_MULI = 5'd8, OP_CMP = 5'd9, OP_JMP = 5'd10, OP_JZ = 5'd11,
        OP_JNZ = 5'd12, OP_JS = 5'd13, OP_JNS = 5'd14, OP_JNZNS = 5'd15,
        OP_MEM = 5'd16, OP_CAS = 5'd17, OP_HALT = 5'd18, OP_EXIT = 5'd19
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_RD1, S_RD2, S_EXEC, S_OUT
    } t_state;
endpackage

[src/tso_accumulator_thread_core.sv]
// Top level of the multi-thread accumulator core with per-thread store buffers.
// A result passes through S_RD1 and S_RD2 (two memory reads), S_EXEC (execute and
// write-back) and S_OUT, which loads the output register.
// A new item is accepted only in S_IDLE, after the last one has loaded the output register;
// one more item is taken while a result waits, and it holds in the output stage until that result is taken.
// Reset starts a clearing pass that zeroes memory; configuration writes go on.
module tso_accumulator_thread_core import tso_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // thread, opcode, operand, indirect
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // new_pc, new_accu, thread_status, run_done,
                                       // exit_value, buffer_full, mem_written,
                                       // written_addr, written_data
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [WORD_BITS-1:0] r_mem [MEM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we, mem_re;
    logic [ADDR_BITS-1:0] mem_wa, mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    logic [31:0] r_bound;
    logic [15:0] r_len [THREADS];
    logic [15:0] r_pc [THREADS], r_acc [THREADS], r_cmp [THREADS];
    logic [15:0] r_baddr [THREADS], r_bdata [THREADS];
    logic        r_bval [THREADS];
    logic [1:0]  r_st [THREADS];
    logic [31:0] r_steps;
    logic [15:0] r_exit;

    t_state r_state, n_state;
    logic [ADDR_BITS-1:0] r_clr;
    logic [TID_BITS-1:0] r_t;
    logic r_kind, r_ind;
    logic [4:0] r_op;
    logic [15:0] r_arg, r_ea;
    logic r_ovalid;
    logic [87:0] r_odata;
    logic r_wr;
    logic [15:0] r_wa, r_wd;

    logic done_now, active, fwd1, fwd2;
    logic [15:0] word1, word2, ea_d;
    logic [15:0] acc, pc0, newacc, npc_try, newpc, len;
    logic take, ctrl, upd;
    logic [1:0] newst;
    logic [31:0] prod;

    always_comb begin
        logic all_h;
        all_h = 1'b1;
        done_now = 1'b0;
        for (int i = 0; i < THREADS; i++) begin
            if (r_st[i] == ST_EXIT) done_now = 1'b1;
            if (r_st[i] != ST_HALT) all_h = 1'b0;
        end
        done_now = done_now | all_h;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    assign active = !done_now && r_st[r_t] == ST_RUN && ({1'b0, r_steps} + 33'd1)
                    <= {1'b0, r_bound};
    assign fwd1 = r_bval[r_t] && r_baddr[r_t] == r_arg;
    assign word1 = fwd1 ? r_bdata[r_t] : r_rdata;
    assign ea_d = r_ind ? word1 : r_arg;
    assign fwd2 = r_bval[r_t] && r_baddr[r_t] == r_ea;
    assign word2 = fwd2 ? r_bdata[r_t] : r_rdata;
    assign acc = r_acc[r_t];
    assign pc0 = r_pc[r_t];
    assign len = r_len[r_t];
    assign prod = acc * word2;

    always_comb begin
        n_state = r_state;
        mem_re = 1'b0;
        mem_ra = r_arg;
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == ADDR_BITS'(MEM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_RD1;
            S_RD1: begin
                mem_re = 1'b1;
                mem_ra = r_arg;
                n_state = S_RD2;
            end
            S_RD2: begin
                mem_re = 1'b1;
                mem_ra = ea_d;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
                if (upd && r_kind && r_bval[r_t]) begin
                    mem_we = 1'b1;
                    mem_wa = r_baddr[r_t];
                    mem_wd = r_bdata[r_t];
                end else if (upd && !r_kind && r_op == OP_CAS && r_cmp[r_t] == word2) begin
                    mem_we = 1'b1;
                    mem_wa = r_ea;
                    mem_wd = acc;
                end
            end
            S_OUT: if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign upd = active;

    always_comb begin
        take = 1'b0;
        ctrl = 1'b0;
        newacc = acc;
        newst = ST_RUN;
        npc_try = pc0 + 16'd1;
        case (r_op)
            OP_JMP: take = 1'b1;
            OP_JZ: take = acc == 0;
            OP_JNZ: take = acc != 0;
            OP_JS: take = acc[15];
            OP_JNS: take = !acc[15];
            OP_JNZNS: take = !acc[15] && acc != 0;
            default: take = 1'b0;
        endcase
        if (r_op >= OP_JMP && r_op <= OP_JNZNS) begin
            ctrl = 1'b1;
            if (take) npc_try = r_arg;
        end
        if (r_op == OP_HALT) begin
            ctrl = 1'b1;
            newst = ST_HALT;
        end
        if (r_op == OP_EXIT) begin
            ctrl = 1'b1;
            newst = ST_EXIT;
        end
        case (r_op)
            OP_LOAD, OP_MEM: newacc = word2;
            OP_ADD: newacc = acc + word2;
            OP_ADDI: newacc = acc + r_arg;
            OP_SUB, OP_CMP: newacc = acc - word2;
            OP_SUBI: newacc = acc - r_arg;
            OP_MUL: newacc = prod[15:0];
            OP_MULI: newacc = 16'(acc * r_arg);
            OP_CAS: newacc = (r_cmp[r_t] == word2) ? 16'd1 : 16'd0;
            default: newacc = acc;
        endcase
        if (!ctrl && len != 0 && pc0 == len - 16'd1) newst = ST_HALT;
        newpc = ({1'b0, npc_try} < {1'b0, len} && r_op != OP_HALT && r_op != OP_EXIT)
                ? npc_try : pc0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_bound <= '1;
            r_steps <= '0;
            r_exit <= '0;
            for (int i = 0; i < THREADS; i++) begin
                r_len[i] <= 16'd1;
                r_pc[i] <= '0;
                r_acc[i] <= '0;
                r_cmp[i] <= '0;
                r_baddr[i] <= '0;
                r_bdata[i] <= '0;
                r_bval[i] <= 1'b0;
                r_st[i] <= ST_RUN;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BOUND) r_bound <= i_cfg_data;
                else if (i_cfg_index >= CFG_LEN0 && i_cfg_index <= CFG_LEN3)
                    r_len[2'(i_cfg_index - CFG_LEN0)] <= i_cfg_data[15:0];
            end
            if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready) begin
                r_t <= s_axis_tdata[1:0];
                r_op <= s_axis_tdata[6:2];
                r_arg <= s_axis_tdata[22:7];
                r_ind <= s_axis_tdata[23];
                r_kind <= s_axis_tuser;
            end
            if (r_state == S_RD2) r_ea <= ea_d;
            if (r_state == S_EXEC) begin
                r_wr <= mem_we;
                r_wa <= mem_we ? mem_wa : '0;
                r_wd <= mem_we ? mem_wd : '0;
                if (!done_now && r_st[r_t] == ST_RUN && r_steps != '1)
                    r_steps <= r_steps + 32'd1;
                if (upd && r_kind) begin
                    if (r_bval[r_t]) r_bval[r_t] <= 1'b0;
                end else if (upd) begin
                    r_pc[r_t] <= newpc;
                    r_st[r_t] <= newst;
                    if (r_op == OP_EXIT) r_exit <= r_arg;
                    if (!ctrl) r_acc[r_t] <= newacc;
                    if (r_op == OP_MEM) r_cmp[r_t] <= word2;
                    if (r_op == OP_STORE) begin
                        r_baddr[r_t] <= r_ea;
                        r_bdata[r_t] <= acc;
                        r_bval[r_t] <= 1'b1;
                    end
                end
            end
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_odata <= {3'b000, r_wd, r_wa, r_wr, r_bval[r_t], r_exit, done_now,
                            r_st[r_t], r_acc[r_t], r_pc[r_t]};
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

[dv/tb_tso_accumulator_thread_core.sv]
// Self-checking testbench for the multi-thread accumulator core with store buffers.
`timescale 1ns / 100ps

module tb_tso_accumulator_thread_core;
    import tso_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [15:0] wdata;
        logic [15:0] waddr;
        logic        wr;
        logic        bfull;
        logic [15:0] exitv;
        logic        done;
        logic [1:0]  status;
        logic [15:0] accu;
        logic [15:0] pc;
    } t_step_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // thread, opcode, operand, indirect
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;   // new_pc, new_accu, thread_status, run_done, exit_value,
                                 // buffer_full, mem_written, written_addr, written_data
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    tso_accumulator_thread_core dut (.*);

    // Machine state mirrored by the predictor.
    logic [31:0] bound_cfg;
    logic [15:0] len_cfg [4];
    logic [15:0] pc_st [4];
    logic [15:0] acc_st [4];
    logic [15:0] cmp_st [4];
    logic [15:0] sb_addr [4];
    logic [15:0] sb_data [4];
    logic        sb_valid [4];
    logic [1:0]  status_st [4];
    logic [15:0] mem_st [65536];
    logic [31:0] steps;
    logic [15:0] exit_st;
    logic        wr_flag;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;

    t_step_result expected_results[$];
    int errors;
    int sent_count;
    int checked_count;
    int writes_seen;
    int idle_cycles;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic run_finished();
        logic all_halted;
        all_halted = 1'b1;
        for (int i = 0; i < THREADS; i++) begin
            if (status_st[i] == ST_EXIT) return 1'b1;
            if (status_st[i] != ST_HALT) all_halted = 1'b0;
        end
        return all_halted;
    endfunction

    function automatic logic [15:0] read_word(int t, logic [15:0] a);
        if (sb_valid[t] && sb_addr[t] == a) return sb_data[t];
        return mem_st[a];
    endfunction

    function automatic logic [15:0] eff_addr(int t, logic [15:0] arg, logic ind);
        return ind ? read_word(t, arg) : arg;
    endfunction

    task automatic mem_store(logic [15:0] a, logic [15:0] v);
        mem_st[a] = v;
        wr_flag = 1'b1;
        wr_addr = a;
        wr_data = v;
    endtask

    task automatic move_pc(int t, int v);
        if (v < int'(len_cfg[t])) pc_st[t] = v[15:0];
    endtask

    task automatic execute_instr(int t, t_op op, logic [15:0] arg, logic ind);
        logic [15:0] pc0;
        logic [15:0] acc;
        logic        neg;
        logic        ctrl;
        logic        take;
        pc0 = pc_st[t];
        acc = acc_st[t];
        neg = acc[15];
        ctrl = 1'b0;
        take = 1'b0;
        if (op inside {OP_JMP, OP_JZ, OP_JNZ, OP_JS, OP_JNS, OP_JNZNS}) begin
            ctrl = 1'b1;
            case (op)
                OP_JMP: take = 1'b1;
                OP_JZ: take = (acc == 0);
                OP_JNZ: take = (acc != 0);
                OP_JS: take = neg;
                OP_JNS: take = !neg;
                default: take = !neg && acc != 0;
            endcase
            move_pc(t, take ? int'(arg) : int'(pc0) + 1);
        end else if (op == OP_HALT) begin
            ctrl = 1'b1;
            status_st[t] = ST_HALT;
        end else if (op == OP_EXIT) begin
            ctrl = 1'b1;
            exit_st = arg;
            status_st[t] = ST_EXIT;
        end else begin
            move_pc(t, int'(pc0) + 1);
            case (op)
                OP_LOAD: acc = read_word(t, eff_addr(t, arg, ind));
                OP_STORE: begin
                    sb_addr[t] = eff_addr(t, arg, ind);
                    sb_data[t] = acc;
                    sb_valid[t] = 1'b1;
                end
                OP_ADD: acc = acc + read_word(t, eff_addr(t, arg, ind));
                OP_ADDI: acc = acc + arg;
                OP_SUB, OP_CMP: acc = acc - read_word(t, eff_addr(t, arg, ind));
                OP_SUBI: acc = acc - arg;
                OP_MUL: acc = acc * read_word(t, eff_addr(t, arg, ind));
                OP_MULI: acc = acc * arg;
                OP_MEM: begin
                    acc = read_word(t, eff_addr(t, arg, ind));
                    cmp_st[t] = acc;
                end
                OP_CAS: begin
                    if (cmp_st[t] == read_word(t, eff_addr(t, arg, ind))) begin
                        mem_store(eff_addr(t, arg, ind), acc);
                        acc = 16'd1;
                    end else begin
                        acc = 16'd0;
                    end
                end
                default: ;
            endcase
            acc_st[t] = acc;
        end
        if (!ctrl && len_cfg[t] != 0 && int'(pc0) == int'(len_cfg[t]) - 1)
            status_st[t] = ST_HALT;
    endtask

    task automatic tso_step_predict(logic [1:0] t, logic kind, logic [4:0] op,
                                    logic [15:0] arg, logic ind, output t_step_result r);
        logic [32:0] num;
        wr_flag = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (!run_finished() && status_st[t] == ST_RUN) begin
            num = {1'b0, steps} + 33'd1;
            if (steps != 32'hFFFF_FFFF) steps = steps + 1;
            if (num <= {1'b0, bound_cfg}) begin
                if (kind) begin
                    if (sb_valid[t]) begin
                        sb_valid[t] = 1'b0;
                        mem_store(sb_addr[t], sb_data[t]);
                    end
                end else begin
                    execute_instr(t, t_op'(op), arg, ind);
                end
            end
        end
        r.pc = pc_st[t];
        r.accu = acc_st[t];
        r.status = status_st[t];
        r.done = run_finished();
        r.exitv = exit_st;
        r.bfull = sb_valid[t];
        r.wr = wr_flag;
        r.waddr = wr_addr;
        r.wdata = wr_data;
    endtask

    task automatic send_item(logic [1:0] t, logic kind, logic [4:0] op,
                             logic [15:0] arg, logic ind);
        t_step_result r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ind, arg, op, t};
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        tso_step_predict(t, kind, op, arg, ind, r);
        expected_results = {expected_results, r};
        sent_count++;
    endtask

    task automatic exec_op(logic [1:0] t, t_op op, logic [15:0] arg, logic ind = 1'b0);
        send_item(t, 1'b0, op, arg, ind);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_BOUND) bound_cfg = val;
        else len_cfg[idx - CFG_LEN0] = val[15:0];
    endtask

    task automatic test_step_bound_zero();
        write_reg(CFG_BOUND, 32'd0);
        for (int i = 0; i < 4; i++) write_reg(CFG_LEN0 + 3'(i), 32'd65535);
        exec_op(2'd0, OP_ADDI, 16'd5);
        exec_op(2'd1, OP_STORE, 16'd3);
        wait_idle();
        write_reg(CFG_BOUND, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        exec_op(2'd0, OP_ADDI, 16'hFFFF);
        exec_op(2'd0, OP_STORE, 16'hFFFF, 1'b0);
        exec_op(2'd0, OP_LOAD, 16'hFFFF);
        exec_op(2'd0, OP_STORE, 16'h0005);
        send_item(2'd0, 1'b1, OP_FENCE, 16'd0, 1'b0);
        send_item(2'd0, 1'b1, OP_FENCE, 16'd0, 1'b0);
        exec_op(2'd1, OP_LOAD, 16'h0005, 1'b1);
        exec_op(2'd1, OP_MEM, 16'h0005);
        exec_op(2'd1, OP_STORE, 16'h0009);
        exec_op(2'd1, OP_CAS, 16'h0005);
        exec_op(2'd1, OP_CAS, 16'h0005);
        exec_op(2'd2, OP_ADD, 16'h0005);
        exec_op(2'd2, OP_MUL, 16'h0005);
        exec_op(2'd2, OP_MULI, 16'h8000);
        exec_op(2'd2, OP_SUB, 16'h0005);
        exec_op(2'd2, OP_SUBI, 16'h0001);
        exec_op(2'd2, OP_CMP, 16'h0005);
        exec_op(2'd2, OP_JS, 16'd40);
        exec_op(2'd2, OP_JNS, 16'd7);
        exec_op(2'd2, OP_JZ, 16'd3);
        exec_op(2'd2, OP_JNZ, 16'hFFFF);
        exec_op(2'd2, OP_JNZNS, 16'd2);
        exec_op(2'd2, t_op'(5'd31), 16'd0);
        exec_op(2'd3, OP_HALT, 16'd0);
        exec_op(2'd3, OP_LOAD, 16'h0005);
        wait_idle();
    endtask

    task automatic test_zero_length();
        write_reg(CFG_LEN0 + 3'd2, 32'd0);
        exec_op(2'd2, OP_ADDI, 16'd1);
        exec_op(2'd2, OP_JMP, 16'd0);
        exec_op(2'd2, OP_FENCE, 16'd0);
        wait_idle();
        write_reg(CFG_LEN0 + 3'd2, 32'd65535);
    endtask

    task automatic random_items(int count);
        logic [4:0]  op;
        logic [15:0] arg;
        for (int i = 0; i < count; i++) begin
            op = 5'($urandom_range(0, 31));
            if (op == OP_HALT || op == OP_EXIT) op = OP_FENCE;
            if (op inside {[OP_JMP:OP_JNZNS]})
                arg = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
            else
                arg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
            send_item(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                      $urandom_range(0, 4) == 0, op, arg, 1'($urandom));
        end
    endtask

    task automatic test_bound_edge();
        write_reg(CFG_BOUND, steps + 32'd4);
        random_items(10);
        wait_idle();
        write_reg(CFG_BOUND, 32'hFFFF_FFFF);
    endtask

    task automatic test_finish();
        write_reg(CFG_LEN0 + 3'd1, 32'(pc_st[1]) + 32'd1);
        exec_op(2'd1, OP_ADDI, 16'd1);
        exec_op(2'd0, OP_EXIT, 16'hA5C3);
        exec_op(2'd2, OP_ADDI, 16'd1);
        send_item(2'd0, 1'b1, OP_FENCE, 16'd0, 1'b0);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (((checked_count / 48) % 3) == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[84:0];
            checked_count++;
            if (got.wr) writes_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %h", got);
                errors++;
            end else begin
                exp = expected_results.pop_front();
                if (got.pc !== exp.pc) begin
                    $error("new_pc expected %h actual %h", exp.pc, got.pc); errors++;
                end
                if (got.accu !== exp.accu) begin
                    $error("new_accu expected %h actual %h", exp.accu, got.accu); errors++;
                end
                if (got.status !== exp.status) begin
                    $error("thread_status expected %h actual %h", exp.status, got.status);
                    errors++;
                end
                if (got.done !== exp.done) begin
                    $error("run_done expected %h actual %h", exp.done, got.done); errors++;
                end
                if (got.exitv !== exp.exitv) begin
                    $error("exit_value expected %h actual %h", exp.exitv, got.exitv); errors++;
                end
                if (got.bfull !== exp.bfull) begin
                    $error("buffer_full expected %h actual %h", exp.bfull, got.bfull); errors++;
                end
                if (got.wr !== exp.wr) begin
                    $error("mem_written expected %h actual %h", exp.wr, got.wr); errors++;
                end
                if (got.waddr !== exp.waddr) begin
                    $error("written_addr expected %h actual %h", exp.waddr, got.waddr); errors++;
                end
                if (got.wdata !== exp.wdata) begin
                    $error("written_data expected %h actual %h", exp.wdata, got.wdata); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tso_accumulator_thread_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        sent_count = 0;
        checked_count = 0;
        writes_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        bound_cfg = 32'hFFFF_FFFF;
        steps = '0;
        exit_st = '0;
        for (int i = 0; i < 4; i++) begin
            len_cfg[i] = 16'd1;
            pc_st[i] = '0;
            acc_st[i] = '0;
            cmp_st[i] = '0;
            sb_addr[i] = '0;
            sb_data[i] = '0;
            sb_valid[i] = 1'b0;
            status_st[i] = ST_RUN;
        end
        for (int a = 0; a < 65536; a++) mem_st[a] = '0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_step_bound_zero();
        test_directed();
        test_zero_length();
        random_items(300);
        wait_idle();
        test_bound_edge();
        random_items(300);
        wait_idle();
        test_finish();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d transactions and checked %0d results, %0d of them memory writes,",
                 sent_count, checked_count, writes_seen);
        $display("across step bounds, zero and short program lengths, and thread exit.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tso_accumulator_thread_core test passed");
        end else begin
            $display("tso_accumulator_thread_core test failed");
        end
        $finish;
    end
endmodule

[sim.f]
src/tso_pkg.sv
src/tso_accumulator_thread_core.sv
dv/tb_tso_accumulator_thread_core.sv
